[src/cmdu_pkg.sv]
// package for the multichannel dac update unit
// shared types, constants and functions, no dependencies
package cmdu_pkg;

  typedef enum logic [1:0] {
    ACT_SETPOINT = 2'd0,
    ACT_MODE     = 2'd1,
    ACT_CAL      = 2'd2,
    ACT_TICK     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_RD,
    BK_MUL,
    BK_SUM,
    BK_EMIT
  } back_state_t;

  localparam logic [1:0]  MODE_INVALID = 2'd3;
  localparam logic [31:0] UNITY_GAIN   = 32'h0001_0000;

  // queued command, front to back
  typedef struct packed {
    action_t     action;
    logic [3:0]  channel;
    logic [31:0] value;
    logic [1:0]  range_mode;
    logic        cal_path;
    logic        cal_field;
  } cmd_t;

  function automatic logic [4:0] addr_map(input logic p, input logic [3:0] ch);
    logic [4:0] a;
    case (ch)
      4'd0: a = 5'd7;   4'd1: a = 5'd5;   4'd2: a = 5'd3;   4'd3: a = 5'd1;
      4'd4: a = 5'd31;  4'd5: a = 5'd29;  4'd6: a = 5'd27;  4'd7: a = 5'd25;
      4'd8: a = 5'd23;  4'd9: a = 5'd21;  4'd10: a = 5'd19; 4'd11: a = 5'd17;
      4'd12: a = 5'd15; 4'd13: a = 5'd13; 4'd14: a = 5'd11; default: a = 5'd9;
    endcase
    return p ? (a - 5'd1) : a;
  endfunction

  function automatic logic signed [31:0] range_lo(input logic [1:0] m);
    return (m == 2'd2) ? -32'sd655360 : 32'sd0;
  endfunction

  function automatic logic signed [31:0] range_hi(input logic [1:0] m);
    case (m)
      2'd0:    return 32'sd327680;
      2'd1:    return 32'sd1310720;
      default: return 32'sd655360;
    endcase
  endfunction

endpackage

[src/calibrated_multichannel_dac_update_unit.sv]
// top level of the calibrated multichannel dac update unit
// depends on cmdu_pkg, cmdu_front and cmdu_back
// flow: items pass a 4-entry queue; an idle back end pops the head item whenever the queue holds one,
// and then applies a setpoint, mode or calibration item directly
// a tick is dequeued, then each channel is scanned; a changed one runs memory read, multiply,
// offset add and emit for each path, and a closing scan follows the last channel
// writes appear delayed by one write so the final one can carry last; the receiver cannot stall
// reset: synchronous active low, clears setpoints, modes, bypass flag and calibration valid bits
module calibrated_multichannel_dac_update_unit #(
  parameter int CHANNELS = 16,
  parameter int CODE_MAX = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_channel,
  input  logic signed [31:0] in_value,
  input  logic [1:0]  in_range_mode,
  input  logic        in_cal_path,
  input  logic        in_cal_field,
  output logic        out_valid,
  output logic [4:0]  out_dac_address,
  output logic [11:0] out_dac_code,
  output logic [3:0]  out_channel,
  output logic        out_current_select,
  output logic        out_last
);
  import cmdu_pkg::*;

  cmd_t cmd_in, q_head;
  logic pop, q_valid;

  // pack the command item
  always_comb begin
    cmd_in.action     = action_t'(in_action);
    cmd_in.channel    = in_channel;
    cmd_in.value      = in_value;
    cmd_in.range_mode = in_range_mode;
    cmd_in.cal_path   = in_cal_path;
    cmd_in.cal_field  = in_cal_field;
  end

  cmdu_front #(.CHANNELS(CHANNELS), .DEPTH(4)) u_front (
    .clk, .rst_n, .start, .busy, .cmd_in, .pop, .q_valid, .q_head
  );

  cmdu_back #(.CHANNELS(CHANNELS), .CODE_MAX(CODE_MAX)) u_back (
    .clk, .rst_n, .q_valid, .q_head, .pop, .out_valid, .out_dac_address,
    .out_dac_code, .out_channel, .out_current_select, .out_last
  );
endmodule

[src/cmdu_front.sv]
// front end: accepts commands, drops ignored ones, pushes to the queue
// depends on cmdu_pkg
module cmdu_front #(
  parameter int CHANNELS = 16,
  parameter int DEPTH    = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cmdu_pkg::cmd_t     cmd_in,
  input  logic               pop,
  output logic               q_valid,
  output cmdu_pkg::cmd_t     q_head
);
  import cmdu_pkg::*;

  localparam int AW = $clog2(DEPTH);

  cmd_t          q_mem [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          keep, push;

  always_comb begin
    keep = 1'b1;
    if (cmd_in.action != ACT_TICK) begin
      if ({1'b0, cmd_in.channel} >= 5'(CHANNELS)) keep = 1'b0;
      else if (cmd_in.action != ACT_SETPOINT && cmd_in.range_mode == MODE_INVALID)
        keep = 1'b0;
    end
  end

  assign busy    = (cnt_r == (AW+1)'(DEPTH));
  assign push    = start && !busy && keep;
  assign q_valid = (cnt_r != '0);
  assign q_head  = q_mem[rd_r];

  always_comb begin
    wr_nxt  = push ? AW'((32'(wr_r) + 1) % DEPTH) : wr_r;
    rd_nxt  = pop ? AW'((32'(rd_r) + 1) % DEPTH) : rd_r;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; cnt_r <= '0;
    end else begin
      wr_r <= wr_nxt; rd_r <= rd_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_r] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst_n) begin
      assert (!(pop && !q_valid)) else $error("pop from empty queue");
      assert (cnt_r <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    end
  end
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy && !pop |=> busy) else $error("full queue lost an entry");
endmodule

[src/cmdu_back.sv]
// back end: applies commands, scans channels on a tick, computes codes
// depends on cmdu_pkg
module cmdu_back #(
  parameter int CHANNELS = 16,
  parameter int CODE_MAX = 4095
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  cmdu_pkg::cmd_t q_head,
  output logic           pop,
  output logic           out_valid,
  output logic [4:0]     out_dac_address,
  output logic [11:0]    out_dac_code,
  output logic [3:0]     out_channel,
  output logic           out_current_select,
  output logic           out_last
);
  import cmdu_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  back_state_t st_r, st_nxt;

  logic signed [31:0] pend_sp_r [CHANNELS];
  logic signed [31:0] appl_sp_r [CHANNELS];
  logic [1:0]         pend_md_r [CHANNELS];
  logic [1:0]         appl_md_r [CHANNELS];
  logic               bypass_r;

  // calibration memories, valid bit per entry gives reset value
  logic [31:0] gain_mem [96];
  logic [31:0] offs_mem [96];
  logic [95:0] gain_v_r, offs_v_r;
  logic [31:0] gain_rd_r, offs_rd_r;
  logic        gain_vr_r, offs_vr_r;

  logic [CW-1:0] ch_r;
  logic          path_r;
  logic [1:0]    m_r;
  logic signed [31:0] sp_r;
  logic signed [63:0] prod_r;
  logic signed [64:0] sum_r;
  logic          pend_emit_r;

  // finished write waiting for the next one or for the end of the scan
  logic [4:0]    hold_addr_r;
  logic [11:0]   hold_code_r;
  logic [3:0]    hold_ch_r;
  logic          hold_cur_r;

  logic [6:0] wr_idx, rd_idx;
  logic signed [31:0] clamped;
  logic [1:0]         m_eff;
  logic               changed, last_ch;

  assign wr_idx = 7'({q_head.cal_path, 6'd0}) - 7'({q_head.cal_path, 4'd0})
                  + 7'({q_head.range_mode, 4'd0}) + 7'(q_head.channel);
  assign rd_idx = (path_r ? 7'd48 : 7'd0) + 7'({m_r, 4'd0}) + 7'(ch_r);

  always_comb begin
    m_eff   = (pend_md_r[ch_r] == MODE_INVALID) ? appl_md_r[ch_r] : pend_md_r[ch_r];
    clamped = pend_sp_r[ch_r];
    if (!bypass_r) begin
      if (clamped < range_lo(m_eff)) clamped = range_lo(m_eff);
      if (clamped > range_hi(m_eff)) clamped = range_hi(m_eff);
    end
    changed = (clamped != appl_sp_r[ch_r]) || (m_eff != appl_md_r[ch_r]);
    last_ch = (32'(ch_r) == CHANNELS - 1);
  end

  always_comb begin
    st_nxt = st_r;
    pop    = 1'b0;
    case (st_r)
      BK_IDLE: if (q_valid) begin
        pop = 1'b1;
        if (q_head.action == ACT_TICK) st_nxt = BK_SCAN;
      end
      BK_SCAN: begin
        if (changed) st_nxt = BK_RD;
        else if (last_ch) st_nxt = BK_IDLE;
      end
      BK_RD:   st_nxt = BK_MUL;
      BK_MUL:  st_nxt = BK_SUM;
      BK_SUM:  st_nxt = BK_EMIT;
      BK_EMIT: begin
        // after the last channel one more scan finds nothing and flushes
        if (!path_r) st_nxt = BK_RD;
        else st_nxt = BK_SCAN;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      bypass_r <= 1'b0;
      gain_v_r <= '0;
      offs_v_r <= '0;
      ch_r <= '0;
      path_r <= 1'b0;
      pend_emit_r <= 1'b0;
      out_valid <= 1'b0;
      out_last <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pend_sp_r[i] <= '0; appl_sp_r[i] <= '0;
        pend_md_r[i] <= '0; appl_md_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      out_valid <= 1'b0;
      out_last <= 1'b0;
      // hold one finished write so last can be marked when the scan ends
      case (st_r)
        BK_IDLE: if (pop) begin
          case (q_head.action)
            ACT_SETPOINT: pend_sp_r[q_head.channel[CW-1:0]] <= q_head.value;
            ACT_MODE:     pend_md_r[q_head.channel[CW-1:0]] <= q_head.range_mode;
            ACT_CAL: begin
              if (!q_head.cal_field) begin
                gain_v_r[wr_idx] <= 1'b1;
                if (q_head.value == UNITY_GAIN) bypass_r <= 1'b1;
              end else offs_v_r[wr_idx] <= 1'b1;
            end
            default: begin
              ch_r <= '0; path_r <= 1'b0;
            end
          endcase
        end
        BK_SCAN: begin
          pend_md_r[ch_r] <= m_eff;
          pend_sp_r[ch_r] <= clamped;
          if (changed) begin
            appl_md_r[ch_r] <= m_eff;
            appl_sp_r[ch_r] <= clamped;
            m_r <= m_eff;
            sp_r <= clamped;
            path_r <= 1'b0;
          end else if (last_ch) begin
            if (pend_emit_r) begin
              out_valid <= 1'b1; out_last <= 1'b1; pend_emit_r <= 1'b0;
              out_dac_address <= hold_addr_r;
              out_dac_code <= hold_code_r;
              out_channel <= hold_ch_r;
              out_current_select <= hold_cur_r;
            end
          end else ch_r <= ch_r + CW'(1);
        end
        BK_EMIT: begin
          if (pend_emit_r) begin
            out_valid <= 1'b1;
            out_dac_address <= hold_addr_r;
            out_dac_code <= hold_code_r;
            out_channel <= hold_ch_r;
            out_current_select <= hold_cur_r;
          end
          pend_emit_r <= 1'b1;
          hold_addr_r <= addr_map(path_r, 4'(ch_r));
          hold_code_r <= code_nxt;
          hold_ch_r <= 4'(ch_r);
          hold_cur_r <= (m_r != 2'd2);
          if (!path_r) path_r <= 1'b1;
          else if (!last_ch) ch_r <= ch_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_IDLE && pop && q_head.action == ACT_CAL) begin
      if (!q_head.cal_field) gain_mem[wr_idx] <= q_head.value;
      else offs_mem[wr_idx] <= q_head.value;
    end
    gain_rd_r <= gain_mem[rd_idx];
    offs_rd_r <= offs_mem[rd_idx];
    gain_vr_r <= gain_v_r[rd_idx];
    offs_vr_r <= offs_v_r[rd_idx];
  end

  // datapath: multiply, add offset, saturate
  logic signed [31:0] g_eff, o_eff;
  logic [11:0] code_nxt;
  assign g_eff = gain_vr_r ? $signed(gain_rd_r) : $signed(UNITY_GAIN);
  assign o_eff = offs_vr_r ? $signed(offs_rd_r) : 32'sd0;

  always_comb begin
    if (sum_r > $signed(65'(CODE_MAX) <<< 32)) code_nxt = 12'(CODE_MAX);
    else if (sum_r < 0) code_nxt = '0;
    else code_nxt = sum_r[43:32];
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_MUL) begin
      prod_r <= g_eff * sp_r;
    end
    if (st_r == BK_SUM) begin
      sum_r <= 65'(prod_r) + (65'(o_eff) <<< 16);
    end
  end

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid) else $error("last without strobe");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> st_r == BK_IDLE) else $error("pop outside idle");
  a_emit_code: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_EMIT |-> $past(st_r) == BK_SUM) else $error("emit out of order");
endmodule
